// ===== rtl/suffix_automaton_substring_match_top_defines.svh =====
// Assertion macros used by the module that checks its own logic.
`ifndef SUFFIX_AUTOMATON_SUBSTRING_MATCH_TOP_DEFINES_SVH
`define SUFFIX_AUTOMATON_SUBSTRING_MATCH_TOP_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define SAM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sam: same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define SAM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sam: next-cycle check failed");

`endif

// ===== rtl/sam_pkg.sv =====
`timescale 1ns / 1ps
package sam_pkg;

  localparam int MAX_NODES = 4095;
  localparam int ALPHABET  = 26;

  localparam int NODE_W = 12;
  localparam int LEN_W  = 11;
  localparam int SYM_W  = 5;
  localparam int ACT_W  = 2;
  localparam int COL_W  = $clog2(ALPHABET + 1);

  localparam int TT_DEPTH = (MAX_NODES + 1) * ALPHABET;
  localparam int TT_AW    = $clog2(TT_DEPTH);
  localparam int NL_DEPTH = MAX_NODES + 1;
  localparam int NL_AW    = $clog2(NL_DEPTH);

  localparam logic [LEN_W-1:0]  LEN_MAX = {LEN_W{1'b1}};
  localparam logic [NODE_W-1:0] ROOT    = NODE_W'(1);

  // Request codes.
  localparam logic [ACT_W-1:0] ACT_APPEND = 2'd0;
  localparam logic [ACT_W-1:0] ACT_MATCH  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

  // One entry of the node store: suffix link and length.
  typedef struct packed {
    logic [NODE_W-1:0] link;
    logic [LEN_W-1:0]  len;
  } nl_word_t;

  typedef struct packed {
    logic              we;
    logic [TT_AW-1:0]  waddr;
    logic [NODE_W-1:0] wdata;
    logic              re;
    logic [TT_AW-1:0]  raddr;
  } tt_req_t;

  typedef struct packed {
    logic             we;
    logic [NL_AW-1:0] waddr;
    nl_word_t         wdata;
    logic             re;
    logic [NL_AW-1:0] raddr;
  } nl_req_t;

  // Address of one transition: row per node, one column per symbol.
  function automatic logic [TT_AW-1:0] tt_addr(input logic [NODE_W-1:0] node,
                                               input logic [SYM_W-1:0] sym);
    logic [TT_AW-1:0] base;
    base = TT_AW'(node) * TT_AW'(ALPHABET);
    return base + TT_AW'(sym);
  endfunction

endpackage

// ===== rtl/suffix_automaton_substring_match_top.sv =====
`timescale 1ns / 1ps
// Suffix automaton matcher. A request is taken when start is high and busy is
// low; its result appears on the out_ ports for exactly one cycle with
// out_valid high, and the receiver cannot stall it. Every request is handled
// to completion before the next is taken. A match reads the current node and
// falls back along suffix links until the symbol is found. An append walks its
// suffix chain twice over, empties the new node's row column by column, and
// when a clone is made also copies a row and redirects edges; all of these are
// bound by the single read port of the transition memory. After reset, and for
// a clear request, the block empties the root row with busy high; a clear
// reports its result at the end of that.
module suffix_automaton_substring_match_top import sam_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [ACT_W-1:0]  in_action,
  input  logic [SYM_W-1:0]  in_symbol,
  input  logic              in_query_start,
  output logic              out_valid,
  output logic [LEN_W-1:0]  out_match_len,
  output logic [LEN_W-1:0]  out_best_len,
  output logic              out_full_res,
  output logic [NODE_W-1:0] out_node_count
);

  tt_req_t           tt_req;
  nl_req_t           nl_req;
  logic [NODE_W-1:0] tt_rdata;
  nl_word_t          nl_rdata;

  // Sequencer.
  sam_seq u_seq (
    .clk, .rst_n, .start, .busy,
    .in_action, .in_symbol, .in_query_start,
    .out_valid, .out_match_len, .out_best_len, .out_full_res, .out_node_count,
    .tt_req, .tt_rdata, .nl_req, .nl_rdata
  );

  // Transition memory: one row of symbols per node.
  sam_ram #(.WIDTH(NODE_W), .DEPTH(TT_DEPTH)) u_tt (
    .clk,
    .we(tt_req.we), .waddr(tt_req.waddr), .wdata(tt_req.wdata),
    .re(tt_req.re), .raddr(tt_req.raddr), .rdata(tt_rdata)
  );

  // Node memory: suffix link and length per node.
  sam_ram #(.WIDTH($bits(nl_word_t)), .DEPTH(NL_DEPTH)) u_nl (
    .clk,
    .we(nl_req.we), .waddr(nl_req.waddr), .wdata(nl_req.wdata),
    .re(nl_req.re), .raddr(nl_req.raddr), .rdata(nl_rdata)
  );

endmodule

// ===== rtl/sam_ram.sv =====
`timescale 1ns / 1ps
module sam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/sam_seq.sv =====
`timescale 1ns / 1ps
`include "suffix_automaton_substring_match_top_defines.svh"
module sam_seq import sam_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [ACT_W-1:0]   in_action,
  input  logic [SYM_W-1:0]   in_symbol,
  input  logic               in_query_start,
  output logic               out_valid,
  output logic [LEN_W-1:0]   out_match_len,
  output logic [LEN_W-1:0]   out_best_len,
  output logic               out_full_res,
  output logic [NODE_W-1:0]  out_node_count,
  output tt_req_t            tt_req,
  input  logic [NODE_W-1:0]  tt_rdata,
  output nl_req_t            nl_req,
  input  nl_word_t           nl_rdata
);

  localparam logic [4:0] S_INIT   = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_A1_RD  = 5'd2;
  localparam logic [4:0] S_A1_EV  = 5'd3;
  localparam logic [4:0] S_A1_Q   = 5'd4;
  localparam logic [4:0] S_A1_QEV = 5'd5;
  localparam logic [4:0] S_A_CHK  = 5'd6;
  localparam logic [4:0] S_ZERO   = 5'd7;
  localparam logic [4:0] S_A2_RD  = 5'd8;
  localparam logic [4:0] S_A2_EV  = 5'd9;
  localparam logic [4:0] S_LINK   = 5'd10;
  localparam logic [4:0] S_COPY   = 5'd11;
  localparam logic [4:0] S_R_RD   = 5'd12;
  localparam logic [4:0] S_R_EV   = 5'd13;
  localparam logic [4:0] S_FIX1   = 5'd14;
  localparam logic [4:0] S_FIX2   = 5'd15;
  localparam logic [4:0] S_FIN    = 5'd16;
  localparam logic [4:0] S_M_RD   = 5'd17;
  localparam logic [4:0] S_M_EV   = 5'd18;
  localparam logic [4:0] S_DONE   = 5'd19;

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(ALPHABET - 1);
  localparam logic [COL_W-1:0] COL_END  = COL_W'(ALPHABET);

  logic [4:0]        state_r, state_nxt;
  logic [COL_W-1:0]  cnt_r, cnt_nxt;
  logic [NODE_W-1:0] p_r, p_nxt, q_r, q_nxt, pstop_r, pstop_nxt, cur_r, cur_nxt;
  logic [NODE_W-1:0] link_q_r, link_q_nxt;
  logic [LEN_W-1:0]  len_p_r, len_p_nxt, len_q_r, len_q_nxt;
  logic              need2_r, need2_nxt;
  logic [NODE_W-1:0] nodes_r, nodes_nxt, last_r, last_nxt, mnode_r, mnode_nxt;
  logic [LEN_W-1:0]  last_len_r, last_len_nxt, mlen_r, mlen_nxt, best_r, best_nxt;
  logic              moved_r, moved_nxt, full_r, full_nxt, known_r, known_nxt;
  logic              res_pend_r, res_pend_nxt;
  logic [SYM_W-1:0]  sym_r, sym_nxt;
  logic              out_valid_r;
  logic [LEN_W-1:0]  out_mlen_r, out_best_r;
  logic              out_full_r;
  logic [NODE_W-1:0] out_nodes_r;

  logic [NODE_W-1:0] clone;
  logic [LEN_W-1:0]  cur_len, len_here, len_step;
  logic [NODE_W:0]   room;
  logic [NODE_W-1:0] edge_m;

  assign clone   = cur_r + NODE_W'(1);
  assign cur_len = last_len_r + LEN_W'(1);
  assign busy    = (state_r != S_IDLE);

  // Sequencer over the transition store and the node store.
  always_comb begin
    state_nxt = state_r;  cnt_nxt = cnt_r;  p_nxt = p_r;  q_nxt = q_r;
    pstop_nxt = pstop_r;  cur_nxt = cur_r;  link_q_nxt = link_q_r;
    len_p_nxt = len_p_r;  len_q_nxt = len_q_r;  need2_nxt = need2_r;
    nodes_nxt = nodes_r;  last_nxt = last_r;  mnode_nxt = mnode_r;
    last_len_nxt = last_len_r;  mlen_nxt = mlen_r;  best_nxt = best_r;
    moved_nxt = moved_r;  full_nxt = full_r;  known_nxt = known_r;
    res_pend_nxt = res_pend_r;  sym_nxt = sym_r;
    tt_req = '0;
    nl_req = '0;
    room = {1'b0, nodes_r} + (need2_r ? (NODE_W + 1)'(2) : (NODE_W + 1)'(1));
    len_here = moved_r ? nl_rdata.len : mlen_r;
    edge_m = known_r ? tt_rdata : '0;
    len_step = (len_here < LEN_MAX) ? len_here + LEN_W'(1) : len_here;

    unique case (state_r)
      S_INIT: begin
        // Empty the root row and its link entry.
        tt_req.we    = 1'b1;
        tt_req.waddr = tt_addr(ROOT, SYM_W'(cnt_r));
        tt_req.wdata = '0;
        if (cnt_r == '0) begin
          nl_req.we    = 1'b1;
          nl_req.waddr = NL_AW'(ROOT);
          nl_req.wdata = '0;
        end
        if (cnt_r == COL_LAST) begin
          state_nxt = res_pend_r ? S_DONE : S_IDLE;
        end else begin
          cnt_nxt = cnt_r + COL_W'(1);
        end
      end
      S_IDLE: begin
        if (start) begin
          full_nxt = 1'b0;
          sym_nxt  = in_symbol;
          case (in_action)
            ACT_APPEND: begin
              if (32'(in_symbol) >= ALPHABET) begin
                state_nxt = S_DONE;
              end else if (last_len_r == LEN_MAX) begin
                full_nxt  = 1'b1;
                state_nxt = S_DONE;
              end else begin
                p_nxt     = last_r;
                state_nxt = S_A1_RD;
              end
            end
            ACT_MATCH: begin
              known_nxt = (32'(in_symbol) < ALPHABET);
              moved_nxt = 1'b0;
              if (in_query_start) begin
                mnode_nxt = ROOT;
                mlen_nxt  = '0;
                best_nxt  = '0;
              end
              state_nxt = S_M_RD;
            end
            ACT_CLEAR: begin
              nodes_nxt = ROOT;  last_nxt = ROOT;  last_len_nxt = '0;
              mnode_nxt = ROOT;  mlen_nxt = '0;    best_nxt = '0;
              res_pend_nxt = 1'b1;
              cnt_nxt      = '0;
              state_nxt    = S_INIT;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      // First walk: find where the suffix chain already has this symbol.
      S_A1_RD: begin
        tt_req.re    = 1'b1;
        tt_req.raddr = tt_addr(p_r, sym_r);
        nl_req.re    = 1'b1;
        nl_req.raddr = NL_AW'(p_r);
        state_nxt    = S_A1_EV;
      end
      S_A1_EV: begin
        if (tt_rdata == '0) begin
          if (nl_rdata.link == '0) begin
            pstop_nxt = '0;
            need2_nxt = 1'b0;
            state_nxt = S_A_CHK;
          end else begin
            p_nxt     = nl_rdata.link;
            state_nxt = S_A1_RD;
          end
        end else begin
          pstop_nxt = p_r;
          q_nxt     = tt_rdata;
          len_p_nxt = nl_rdata.len;
          state_nxt = S_A1_Q;
        end
      end
      S_A1_Q: begin
        nl_req.re    = 1'b1;
        nl_req.raddr = NL_AW'(q_r);
        state_nxt    = S_A1_QEV;
      end
      S_A1_QEV: begin
        len_q_nxt  = nl_rdata.len;
        link_q_nxt = nl_rdata.link;
        need2_nxt  = ((len_p_r + LEN_W'(1)) != nl_rdata.len);
        state_nxt  = S_A_CHK;
      end
      S_A_CHK: begin
        if (room > (NODE_W + 1)'(MAX_NODES)) begin
          full_nxt  = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cur_nxt   = nodes_r + NODE_W'(1);
          cnt_nxt   = '0;
          state_nxt = S_ZERO;
        end
      end
      // A fresh node starts with no transitions.
      S_ZERO: begin
        tt_req.we    = 1'b1;
        tt_req.waddr = tt_addr(cur_r, SYM_W'(cnt_r));
        tt_req.wdata = '0;
        if (cnt_r == COL_LAST) begin
          p_nxt     = last_r;
          state_nxt = S_A2_RD;
        end else begin
          cnt_nxt = cnt_r + COL_W'(1);
        end
      end
      // Second walk: point the chain up to the stop node at the new node.
      S_A2_RD: begin
        if (p_r == pstop_r) begin
          state_nxt = S_LINK;
        end else begin
          nl_req.re    = 1'b1;
          nl_req.raddr = NL_AW'(p_r);
          state_nxt    = S_A2_EV;
        end
      end
      S_A2_EV: begin
        tt_req.we    = 1'b1;
        tt_req.waddr = tt_addr(p_r, sym_r);
        tt_req.wdata = cur_r;
        p_nxt        = nl_rdata.link;
        state_nxt    = S_A2_RD;
      end
      S_LINK: begin
        nl_req.we = 1'b1;
        if (pstop_r == '0) begin
          nl_req.waddr = NL_AW'(cur_r);
          nl_req.wdata = '{link: ROOT, len: cur_len};
          state_nxt    = S_FIN;
        end else if (!need2_r) begin
          nl_req.waddr = NL_AW'(cur_r);
          nl_req.wdata = '{link: q_r, len: cur_len};
          state_nxt    = S_FIN;
        end else begin
          nl_req.waddr = NL_AW'(clone);
          nl_req.wdata = '{link: link_q_r, len: len_p_r + LEN_W'(1)};
          cnt_nxt      = '0;
          state_nxt    = S_COPY;
        end
      end
      // Copy the row of q into the clone, one column behind the read.
      S_COPY: begin
        if (cnt_r != COL_END) begin
          tt_req.re    = 1'b1;
          tt_req.raddr = tt_addr(q_r, SYM_W'(cnt_r));
        end
        if (cnt_r != '0) begin
          tt_req.we    = 1'b1;
          tt_req.waddr = tt_addr(clone, SYM_W'(cnt_r - COL_W'(1)));
          tt_req.wdata = tt_rdata;
        end
        if (cnt_r == COL_END) begin
          p_nxt     = pstop_r;
          state_nxt = S_R_RD;
        end else begin
          cnt_nxt = cnt_r + COL_W'(1);
        end
      end
      // Redirect edges into q over to the clone.
      S_R_RD: begin
        if (p_r == '0) begin
          state_nxt = S_FIX1;
        end else begin
          tt_req.re    = 1'b1;
          tt_req.raddr = tt_addr(p_r, sym_r);
          nl_req.re    = 1'b1;
          nl_req.raddr = NL_AW'(p_r);
          state_nxt    = S_R_EV;
        end
      end
      S_R_EV: begin
        if (tt_rdata == q_r) begin
          tt_req.we    = 1'b1;
          tt_req.waddr = tt_addr(p_r, sym_r);
          tt_req.wdata = clone;
          p_nxt        = nl_rdata.link;
          state_nxt    = S_R_RD;
        end else begin
          state_nxt = S_FIX1;
        end
      end
      S_FIX1: begin
        nl_req.we    = 1'b1;
        nl_req.waddr = NL_AW'(q_r);
        nl_req.wdata = '{link: clone, len: len_q_r};
        state_nxt    = S_FIX2;
      end
      S_FIX2: begin
        nl_req.we    = 1'b1;
        nl_req.waddr = NL_AW'(cur_r);
        nl_req.wdata = '{link: clone, len: cur_len};
        state_nxt    = S_FIN;
      end
      S_FIN: begin
        last_nxt     = cur_r;
        last_len_nxt = cur_len;
        nodes_nxt    = room[NODE_W-1:0];
        state_nxt    = S_DONE;
      end
      // Matching: fall back along suffix links until the symbol is found.
      S_M_RD: begin
        tt_req.re    = known_r;
        tt_req.raddr = tt_addr(mnode_r, sym_r);
        nl_req.re    = 1'b1;
        nl_req.raddr = NL_AW'(mnode_r);
        state_nxt    = S_M_EV;
      end
      S_M_EV: begin
        mlen_nxt = len_here;
        if (mnode_r != ROOT && edge_m == '0) begin
          mnode_nxt = nl_rdata.link;
          moved_nxt = 1'b1;
          state_nxt = S_M_RD;
        end else begin
          if (edge_m != '0) begin
            mnode_nxt = edge_m;
            mlen_nxt  = len_step;
            best_nxt  = (len_step > best_r) ? len_step : best_r;
          end else begin
            best_nxt  = (len_here > best_r) ? len_here : best_r;
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        res_pend_nxt = 1'b0;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;  cnt_r <= '0;  res_pend_r <= 1'b0;
      nodes_r <= ROOT;    last_r <= ROOT;  last_len_r <= '0;
      mnode_r <= ROOT;    mlen_r <= '0;    best_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;  cnt_r <= cnt_nxt;  res_pend_r <= res_pend_nxt;
      nodes_r <= nodes_nxt;  last_r <= last_nxt;  last_len_r <= last_len_nxt;
      mnode_r <= mnode_nxt;  mlen_r <= mlen_nxt;  best_r <= best_nxt;
      out_valid_r <= (state_r == S_DONE);
    end
  end

  // Working registers of the walks, and the result registers captured in S_DONE.
  always_ff @(posedge clk) begin
    p_r <= p_nxt;  q_r <= q_nxt;  pstop_r <= pstop_nxt;  cur_r <= cur_nxt;
    link_q_r <= link_q_nxt;  len_p_r <= len_p_nxt;  len_q_r <= len_q_nxt;
    need2_r <= need2_nxt;  moved_r <= moved_nxt;  full_r <= full_nxt;
    known_r <= known_nxt;  sym_r <= sym_nxt;
    if (state_r == S_DONE) begin
      out_mlen_r  <= mlen_r;
      out_best_r  <= best_r;
      out_full_r  <= full_r;
      out_nodes_r <= nodes_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_match_len  = out_mlen_r;
  assign out_best_len   = out_best_r;
  assign out_full_res   = out_full_r;
  assign out_node_count = out_nodes_r;

  `SAM_ASSERT_IMPL(a_strobe_idle, out_valid_r, state_r == S_IDLE)
  `SAM_ASSERT_NEXT(a_accept_leaves, start && state_r == S_IDLE, state_r != S_IDLE)
  `SAM_ASSERT_IMPL(a_nodes_range, 1'b1, nodes_r != '0 && nodes_r <= NODE_W'(MAX_NODES))
  `SAM_ASSERT_IMPL(a_tt_port, tt_req.we && tt_req.re, tt_req.waddr != tt_req.raddr)

endmodule
